/* hw/rtl/wrs_pkg.sv */
// Shared types and constants for the weighted random selector.
package wrs_pkg;

  // Fixed widths of the word fields
  localparam int WEIGHT_W = 16;
  localparam int DRAW_W   = 17;
  localparam int INDEX_W  = 6;
  localparam int FRAC_W   = 16;

  // A draw of one whole, i.e. 65536 over 65536
  localparam logic [DRAW_W-1:0] DRAW_ONE = 17'h10000;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_PUT  = 4'b1000
  } state_t;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

/* hw/rtl/wrs_accum.sv */
// Running-sum accumulator and threshold compare for the selection scan.
module wrs_accum #(
  parameter int STORE_W = 16,
  parameter int RUN_W   = 23
) (
  input  logic                             clk,
  input  wrs_pkg::acc_ctrl_t               ctrl,
  input  logic [STORE_W-1:0]               addend,
  input  logic [RUN_W+wrs_pkg::DRAW_W-1:0] scaled,
  output logic                             hit
);
  import wrs_pkg::*;

  localparam int CMP_W = RUN_W + DRAW_W;

  logic [RUN_W-1:0] run;
  logic [RUN_W-1:0] run_next;
  logic [CMP_W-1:0] run_scaled;

  // Sum including the word now arriving from the store
  assign run_next   = run + RUN_W'(addend);
  assign run_scaled = {{(DRAW_W-FRAC_W){1'b0}}, run_next, {FRAC_W{1'b0}}};

  // First entry whose running sum passes total * draw
  assign hit = ctrl.add && (run_scaled > scaled);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      run <= '0;
    end else if (ctrl.add) begin
      run <= run_next;
    end
  end

endmodule

/* hw/rtl/weighted_random_selector.sv */
// Top level of the weighted random selector.
//
// Roulette wheel selection. Each input word loads one candidate into the
// weight store; ineligible or zero-weight candidates are stored as zero and
// never chosen. A word with last set ends the round: the block scales the
// total weight by the draw in the multiply state, then scans the store from
// entry 0 at one entry per cycle through its single read port, and stops at
// the first entry whose running sum exceeds the scaled value. While the round
// is being scaled and scanned, and while its result waits to be handed to
// the output register, further input words are stalled. Candidates beyond
// MAX_ENTRIES are dropped. found is 0 with selected_index 0 when nothing
// qualifies or the draw is one whole.
// The result sits in an output register, so loading of the next round may
// begin while it waits to be taken. The store needs no clearing after reset.
module weighted_random_selector #(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wrs_pkg::WEIGHT_W-1:0]  weight,
  input  logic                          eligible,
  input  logic                          last,
  input  logic [wrs_pkg::DRAW_W-1:0]    random_draw,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wrs_pkg::INDEX_W-1:0]   selected_index,
  output logic                          found
);
  import wrs_pkg::*;

  localparam int STORE_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int TOT_W   = STORE_W + CNT_W;
  localparam int SCL_W   = TOT_W + DRAW_W;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [TOT_W-1:0]   total;
  logic [DRAW_W-1:0]  draw;
  logic [SCL_W-1:0]   scaled;
  logic [CNT_W-1:0]   rd_ptr;
  logic               rd_v;
  logic [IDX_W-1:0]   rd_idx;
  logic [STORE_W-1:0] rd_data;
  logic               res_found;
  logic [INDEX_W-1:0] res_index;

  logic [STORE_W-1:0] mem [MAX_ENTRIES];

  logic                 accept;
  logic                 has_room;
  logic                 wr_en;
  logic                 rd_en;
  logic [STORE_W-1:0]   eff;
  logic                 hit;
  logic                 scan_miss;
  logic                 out_free;
  logic [IDX_W+INDEX_W-1:0] idx_wide;
  acc_ctrl_t            acc_ctrl;

  // Input side
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign has_room = (count != CNT_W'(MAX_ENTRIES));
  assign wr_en    = accept && has_room;
  assign eff      = eligible ? weight[STORE_W-1:0] : '0;

  // Scan control
  assign rd_en     = (state == ST_SCAN) && (rd_ptr != count) && !hit;
  assign scan_miss = !rd_v && (rd_ptr == count);
  assign out_free  = !out_valid || !out_stall;
  assign idx_wide  = (IDX_W+INDEX_W)'(rd_idx);

  assign acc_ctrl.clear = (state == ST_MUL);
  assign acc_ctrl.add   = rd_v;

  wrs_accum #(
    .STORE_W (STORE_W),
    .RUN_W   (TOT_W)
  ) u_accum (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .addend (rd_data),
    .scaled (scaled),
    .hit    (hit)
  );

  // Weight store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= eff;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr[IDX_W-1:0]];
    end
    rd_idx <= rd_ptr[IDX_W-1:0];
  end

  // Scaled threshold, registered after the multiply
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      scaled <= SCL_W'(total) * SCL_W'(draw);
    end
  end

  // Sequencer, round state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      total     <= '0;
      rd_ptr    <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= rd_en;
      // Result word: loaded from hand-over, held while stalled
      out_valid <= ((state == ST_PUT) && out_free) || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
              total <= total + TOT_W'(eff);
            end
            if (last) begin
              draw  <= (random_draw > DRAW_ONE) ? DRAW_ONE : random_draw;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          rd_ptr <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (hit || scan_miss) begin
            res_found <= hit;
            res_index <= hit ? idx_wide[INDEX_W-1:0] : '0;
            count     <= '0;
            total     <= '0;
            state     <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            found          <= res_found;
            selected_index <= res_index;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A new result word only ever comes from the hand-over state
  a_out_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_PUT))
    else $error("result word raised outside hand-over");

  // A miss always reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (selected_index == '0))
    else $error("miss with nonzero index");

  // Store reads are only in flight during the scan
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == ST_SCAN))
    else $error("store read outside scan");

  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond store depth");
`endif

endmodule
